// File: rtl/core/palette_hue_rotator_core_macros.svh
// assertion helpers
`ifndef PALETTE_HUE_ROTATOR_CORE_MACROS_SVH
`define PALETTE_HUE_ROTATOR_CORE_MACROS_SVH
`define PHR_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define PHR_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// File: rtl/core/phr_pkg.sv
package phr_pkg;
   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
      logic       last_entry;
   } req_word_type;
   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
      logic       last_out;
   } rsp_word_type;
endpackage

// File: rtl/core/phr_divider.sv
module phr_divider #(
   parameter int NUM_BITS = 24,
   parameter int DEN_BITS = 8,
   parameter int TAG_BITS = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [NUM_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  logic [TAG_BITS-1:0] in_tag,
   output logic                out_valid,
   output logic [NUM_BITS-1:0] out_quo,
   output logic [TAG_BITS-1:0] out_tag
);
   localparam int W = NUM_BITS + DEN_BITS;
   logic [NUM_BITS:0]       vld_ff;
   logic [W-1:0]            rem_ff [NUM_BITS+1];
   logic [NUM_BITS-1:0]     quo_ff [NUM_BITS+1];
   logic [DEN_BITS-1:0]     den_ff [NUM_BITS+1];
   logic [TAG_BITS-1:0]     tag_ff [NUM_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NUM_BITS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= {{DEN_BITS{1'b0}}, in_num};
         quo_ff[0] <= '0;
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
         for (int i = 0; i < NUM_BITS; i++) begin
            logic [W-1:0] trial;
            logic [W-1:0] dsh;
            dsh = {{NUM_BITS{1'b0}}, den_ff[i]} << (NUM_BITS - 1 - i);
            trial = rem_ff[i];
            if (trial >= dsh) begin
               rem_ff[i+1] <= trial - dsh;
               quo_ff[i+1] <= quo_ff[i] | (NUM_BITS'(1) << (NUM_BITS - 1 - i));
            end else begin
               rem_ff[i+1] <= trial;
               quo_ff[i+1] <= quo_ff[i];
            end
            den_ff[i+1] <= den_ff[i];
            tag_ff[i+1] <= tag_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[NUM_BITS];
   assign out_quo   = quo_ff[NUM_BITS];
   assign out_tag   = tag_ff[NUM_BITS];
endmodule

// File: rtl/core/palette_hue_rotator_core.sv
// Palette hue rotator.
// req_ channel: one color word (red, green, blue, alpha, last mark) per
// cycle, accepted when req_valid is high and req_stall is low.
// rsp_ channel: one rotated color per accepted word, in order, taken when
// rsp_valid is high and rsp_stall is low. Alpha and last pass unchanged.
// csr_ channel: writes the 16-bit hue rotation; write only while idle.
// The two restoring dividers run side by side, one quotient bit per
// stage over FRAC_BITS + 8 bits, and set the depth of the pipeline.
// Throughput: one word per cycle while rsp_stall is low.
// Reset clears all valid bits and the rotation register.
// When rsp_stall is high and the output register is full, the whole
// pipeline holds and req_stall rises; nothing is lost or repeated.
`include "palette_hue_rotator_core_macros.svh"
module palette_hue_rotator_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  phr_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output phr_pkg::rsp_word_type rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);
   localparam int F   = FRAC_BITS;
   localparam int NB  = F + 8;
   localparam int HB  = F + 3;
   localparam int TB  = 8 + 8 + 1 + 2 + 1 + 1 + 1;
   localparam logic [HB-1:0] TURN = HB'(6) << F;

   logic [15:0] rot_ff;
   logic        advance;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) rot_ff <= '0;
      else if (csr_valid) rot_ff <= csr_data;
   end

   logic out_full_ff;
   assign advance   = !out_full_ff || !rsp_stall;
   assign req_stall = !advance;

   // stage 1: max, min, sector choice
   logic        v1_ff;
   logic [7:0]  mx1_ff, dl1_ff, dd1_ff, a1_ff;
   logic [1:0]  sec1_ff;
   logic        neg1_ff, last1_ff, col1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      logic [7:0] r, g, b, mx, mn;
      r = req_word.red_in; g = req_word.green_in; b = req_word.blue_in;
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      if (advance) begin
         mx1_ff <= mx;
         dl1_ff <= mx - mn;
         a1_ff <= req_word.alpha_in;
         last1_ff <= req_word.last_entry;
         col1_ff <= (mx != 0) && (mx != mn);
         if (r == mx) begin
            sec1_ff <= 2'd0; neg1_ff <= g < b; dd1_ff <= (g >= b) ? g - b : b - g;
         end else if (g == mx) begin
            sec1_ff <= 2'd1; neg1_ff <= b < r; dd1_ff <= (b >= r) ? b - r : r - b;
         end else begin
            sec1_ff <= 2'd2; neg1_ff <= r < g; dd1_ff <= (r >= g) ? r - g : g - r;
         end
      end
   end

   // two dividers: saturation and hue offset, rounded half up
   logic [NB-1:0] s_num, h_num, s_quo, h_quo;
   logic [TB-1:0] tag_in, tag_out;
   logic [7:0]    hden;
   logic          sv_o, hv_o;
   logic [7:0]    unused_tag;
   assign s_num = {dl1_ff, F'(0)} + NB'(mx1_ff >> 1);
   assign h_num = NB'({dd1_ff, F'(0)}) + NB'(dl1_ff >> 1);
   assign hden  = col1_ff ? dl1_ff : 8'd1;
   assign tag_in = {mx1_ff, a1_ff, last1_ff, sec1_ff, neg1_ff, col1_ff, 1'b0};

   phr_divider #(.NUM_BITS(NB), .DEN_BITS(8), .TAG_BITS(TB)) u_sdiv (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v1_ff),
      .in_num(s_num), .in_den(col1_ff ? mx1_ff : 8'd1), .in_tag(tag_in),
      .out_valid(sv_o), .out_quo(s_quo), .out_tag(tag_out));
   phr_divider #(.NUM_BITS(NB), .DEN_BITS(8), .TAG_BITS(8)) u_hdiv (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v1_ff),
      .in_num(h_num), .in_den(hden), .in_tag(8'd0),
      .out_valid(hv_o), .out_quo(h_quo), .out_tag(unused_tag));

   // stage: hue assembly and rotation
   logic          v3_ff;
   logic [HB-1:0] h3_ff;
   logic [F:0]    s3_ff;
   logic [7:0]    mx3_ff, a3_ff;
   logic          last3_ff;
   logic [HB-1:0] rot_w;
   logic [16+3+F-1:0] rprod;
   assign rprod = ({(19+F-16)'(0), rot_ff} * (19+F)'(6)) << F;
   assign rot_w = HB'((rprod + (19+F)'(32768)) >> 16);
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= sv_o;
   end
   always_ff @(posedge clock) begin
      logic [HB:0] h, base, off;
      logic [HB:0] rr;
      base = (HB+1)'(tag_out[4:3]) << (F + 1);
      off  = (HB+1)'(h_quo[F:0]);
      if (tag_out[1]) begin
         if (tag_out[2]) h = (tag_out[4:3] == 2'd0) ? (HB+1)'(TURN) - off : base - off;
         else h = base + off;
         if (h >= (HB+1)'(TURN)) h = h - (HB+1)'(TURN);
      end else h = '0;
      rr = (rot_w >= TURN) ? (HB+1)'(rot_w - TURN) : (HB+1)'(rot_w);
      h = h + rr;
      if (h >= (HB+1)'(TURN)) h = h - (HB+1)'(TURN);
      if (advance) begin
         h3_ff <= h[HB-1:0];
         s3_ff <= tag_out[1] ? s_quo[F:0] : '0;
         mx3_ff <= tag_out[TB-1 -: 8];
         a3_ff <= tag_out[TB-9 -: 8];
         last3_ff <= tag_out[TB-17];
      end
   end

   // stage: s * f products
   logic          v4_ff;
   logic [2*F+1:0] kp4_ff, kq4_ff, kt4_ff;
   logic [2:0]    j4_ff;
   logic [7:0]    mx4_ff, a4_ff;
   logic          last4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      logic [F:0] fr;
      logic [2*F+1:0] one2;
      fr = {1'b0, h3_ff[F-1:0]};
      one2 = (2*F+2)'(1) << (2*F);
      if (advance) begin
         kp4_ff <= one2 - ((2*F+2)'(s3_ff) << F);
         kq4_ff <= one2 - (2*F+2)'(s3_ff) * (2*F+2)'(fr);
         kt4_ff <= one2 - (2*F+2)'(s3_ff) * (2*F+2)'((F+1)'(1 << F) - fr);
         j4_ff <= h3_ff[HB-1:F];
         mx4_ff <= mx3_ff; a4_ff <= a3_ff; last4_ff <= last3_ff;
      end
   end

   // stage: scale by value and round
   logic          v5_ff;
   logic [7:0]    p5_ff, q5_ff, t5_ff, mx5_ff, a5_ff;
   logic [2:0]    j5_ff;
   logic          last5_ff;
   function automatic logic [7:0] scale(input logic [7:0] v, input logic [2*F+1:0] k);
      logic [2*F+9:0] pr;
      pr = (2*F+10)'(v) * (2*F+10)'(k) + ((2*F+10)'(1) << (2*F-1));
      return pr[2*F+7:2*F];
   endfunction
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (advance) v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         p5_ff <= scale(mx4_ff, kp4_ff);
         q5_ff <= scale(mx4_ff, kq4_ff);
         t5_ff <= scale(mx4_ff, kt4_ff);
         j5_ff <= j4_ff; mx5_ff <= mx4_ff; a5_ff <= a4_ff; last5_ff <= last4_ff;
      end
   end

   // output register
   phr_pkg::rsp_word_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) out_full_ff <= 1'b0;
      else if (advance) out_full_ff <= v5_ff;
   end
   always_ff @(posedge clock) begin
      logic [7:0] ro, go, bo;
      case (j5_ff)
         3'd1: begin ro = q5_ff; go = mx5_ff; bo = p5_ff; end
         3'd2: begin ro = p5_ff; go = mx5_ff; bo = t5_ff; end
         3'd3: begin ro = p5_ff; go = q5_ff; bo = mx5_ff; end
         3'd4: begin ro = t5_ff; go = p5_ff; bo = mx5_ff; end
         3'd5: begin ro = mx5_ff; go = p5_ff; bo = q5_ff; end
         default: begin ro = mx5_ff; go = t5_ff; bo = p5_ff; end
      endcase
      if (advance) begin
         out_ff <= '{red_out: ro, green_out: go, blue_out: bo,
                     alpha_out: a5_ff, last_out: last5_ff};
      end
   end
   assign rsp_valid = out_full_ff;
   assign rsp_word  = out_ff;

   `PHR_ASSERT_IMPL(a_dividers_aligned, clock, reset, 1'b1, sv_o == hv_o)
   `PHR_ASSERT_IMPL(a_stall_only_when_full, clock, reset, req_stall, out_full_ff)
   `PHR_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_word))
endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
module tb;

   localparam int FB = 16;
   localparam longint ONE_L = 64'd1 << FB;
   localparam longint TURN_L = 6 * ONE_L;
   localparam int LATENCY = FB + 13;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   phr_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   phr_pkg::rsp_word_type rsp_word;
   logic csr_valid = 0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   palette_hue_rotator_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   phr_pkg::req_word_type pending_colors[$];
   phr_pkg::rsp_word_type rotated_colors[$];
   logic [15:0] rotation = 0;
   int errors = 0;
   bit quiet = 0;
   int req_idle = 0;
   int rsp_idle = 0;

   function automatic longint rdiv(longint num, longint den);
      return (num + den / 2) / den;
   endfunction

   function automatic longint scale_level(longint v, longint k);
      longint prod;
      prod = v * k;
      return (prod + (64'd1 << (2 * FB - 1))) >> (2 * FB);
   endfunction

   function automatic phr_pkg::rsp_word_type rotate_color(phr_pkg::req_word_type w,
                                                          logic [15:0] rot_reg);
      longint r, g, b, mx, mn, del, s, h, rot, j, f, pv, qv, tv;
      phr_pkg::rsp_word_type o;
      r = w.red_in; g = w.green_in; b = w.blue_in;
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      del = mx - mn; s = 0; h = 0;
      if (mx != 0 && del != 0) begin
         s = rdiv(del << FB, mx);
         if (r == mx) begin
            if (g >= b) h = rdiv((g - b) << FB, del);
            else h = TURN_L - rdiv((b - g) << FB, del);
         end else if (g == mx) begin
            if (b >= r) h = 2 * ONE_L + rdiv((b - r) << FB, del);
            else h = 2 * ONE_L - rdiv((r - b) << FB, del);
         end else begin
            if (r >= g) h = 4 * ONE_L + rdiv((r - g) << FB, del);
            else h = 4 * ONE_L - rdiv((g - r) << FB, del);
         end
         if (h >= TURN_L) h -= TURN_L;
      end
      rot = ((longint'(rot_reg) * 6 << FB) + 32768) >> 16;
      rot = rot % TURN_L;
      h += rot;
      if (h >= TURN_L) h -= TURN_L;
      j = h >> FB;
      f = h & (ONE_L - 1);
      pv = scale_level(mx, ONE_L * ONE_L - s * ONE_L);
      qv = scale_level(mx, ONE_L * ONE_L - s * f);
      tv = scale_level(mx, ONE_L * ONE_L - s * (ONE_L - f));
      case (j)
         1: begin o.red_out = 8'(qv); o.green_out = 8'(mx); o.blue_out = 8'(pv); end
         2: begin o.red_out = 8'(pv); o.green_out = 8'(mx); o.blue_out = 8'(tv); end
         3: begin o.red_out = 8'(pv); o.green_out = 8'(qv); o.blue_out = 8'(mx); end
         4: begin o.red_out = 8'(tv); o.green_out = 8'(pv); o.blue_out = 8'(mx); end
         5: begin o.red_out = 8'(mx); o.green_out = 8'(pv); o.blue_out = 8'(qv); end
         default: begin o.red_out = 8'(mx); o.green_out = 8'(tv); o.blue_out = 8'(pv); end
      endcase
      o.alpha_out = w.alpha_in;
      o.last_out = w.last_entry;
      return o;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            rotated_colors.push_back(rotate_color(req_word, rotation));
         end
         if (!req_valid || !req_stall) begin
            if (req_idle > 0) begin
               req_idle <= req_idle - 1;
               req_valid <= 0;
            end else if (pending_colors.size() > 0) begin
               req_word <= pending_colors.pop_front();
               req_valid <= 1;
               if (!quiet && $urandom_range(0, 9) == 0) req_idle <= $urandom_range(1, 16);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      phr_pkg::rsp_word_type exp_w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (rotated_colors.size() == 0) begin
               $display("%0t unexpected word actual %h", $time, rsp_word);
               errors++;
            end else begin
               exp_w = rotated_colors.pop_front();
               if (rsp_word !== exp_w) begin
                  $display("%0t mismatch expected %h actual %h", $time, exp_w, rsp_word);
                  errors++;
               end
            end
         end
         if (rsp_idle > 0) begin
            rsp_idle <= rsp_idle - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            if (!quiet && $urandom_range(0, 9) == 0) rsp_idle <= $urandom_range(1, 16);
         end
      end
   end

   task automatic add_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      phr_pkg::req_word_type w;
      w.red_in = r; w.green_in = g; w.blue_in = b;
      w.alpha_in = 8'($urandom); w.last_entry = 1'($urandom);
      pending_colors.push_back(w);
   endtask

   task automatic drain();
      while (pending_colors.size() > 0 || req_valid || rotated_colors.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_rotation(logic [15:0] value);
      csr_data <= value;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      rotation = value;
   endtask

   initial begin
      logic [15:0] settings[6];
      int c, len;
      logic [7:0] base;
      settings = '{16'h0000, 16'hFFFF, 16'h2AAB, 16'h8000, 16'h0001, 16'h5555};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      add_color(8'd0, 8'd0, 8'd0); add_color(8'd255, 8'd255, 8'd255);
      add_color(8'd128, 8'd128, 8'd128);
      add_color(8'd255, 8'd0, 8'd0); add_color(8'd0, 8'd255, 8'd0);
      add_color(8'd0, 8'd0, 8'd255);
      add_color(8'd255, 8'd255, 8'd0); add_color(8'd0, 8'd255, 8'd255);
      add_color(8'd255, 8'd0, 8'd255);
      add_color(8'd255, 8'd0, 8'd1); add_color(8'd200, 8'd100, 8'd200);
      add_color(8'd1, 8'd0, 8'd0);
      add_color(8'd255, 8'd254, 8'd253); add_color(8'd10, 8'd200, 8'd30);
      add_color(8'd5, 8'd6, 8'd255);
      pending_colors.push_back('{8'hFF, 8'h00, 8'h80, 8'hFF, 1'b1});
      pending_colors.push_back('{8'h00, 8'hFF, 8'h80, 8'h00, 1'b0});
      drain();
      for (c = 0; c < 8; c++) begin
         write_rotation(c < 6 ? settings[c] : 16'($urandom));
         add_color(8'd255, 8'd0, 8'd0); add_color(8'd0, 8'd200, 8'd99);
         add_color(8'd77, 8'd77, 8'd77);
         len = (c == 7) ? 150 : 140;
         if (c == 7) quiet = 1;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               base = 8'($urandom);
               add_color(base, 8'(base + $urandom_range(0, 2)),
                         8'(base - $urandom_range(0, 1)));
            end else begin
               add_color(8'($urandom), 8'($urandom), 8'($urandom));
            end
         end
         drain();
      end
      if (errors == 0 && rotated_colors.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
